[hw/rtl/ddrsdm_pkg.sv]
// Shared types and constants for the DDR SDRAM device model.
// No dependencies; used by every module under hw/rtl.
package ddrsdm_pkg;

    localparam int MEM_WORD_BITS = 16;
    localparam int MEM_DEPTH     = 1 << MEM_WORD_BITS;
    localparam int ADDR_SUM_BITS = 29;
    localparam int COL_BITS      = 17;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_BITS    = 2;

    localparam logic [1:0] OP_PASS  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_READ  = 2'd1;
    localparam logic [1:0] PH_WRITE = 2'd2;

    localparam logic [2:0] CMD_READ  = 3'b101;
    localparam logic [2:0] CMD_WRITE = 3'b100;
    localparam logic [2:0] CMD_ACT   = 3'b011;
    localparam logic [2:0] CMD_LMR   = 3'b000;

    localparam logic [1:0] STROBE_HI = 2'd2;
    localparam logic [1:0] STROBE_LO = 2'd1;

    localparam logic [3:0] BURST_SHORT = 4'd4;
    localparam logic [3:0] BURST_LONG  = 4'd8;
    localparam logic [2:0] RL_RESET    = 3'd7;
    localparam logic [3:0] WL_RESET    = 4'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic [MEM_WORD_BITS-1:0] addr;
        logic [15:0]              data;
        logic [1:0]               strobe;
        logic                     mismatch;
    } beat_t;

endpackage

[hw/rtl/ddr_sdram_device_model_unit.sv]
// DDR SDRAM device model, top level: front end, word queue and memory back end.
// Depends on ddrsdm_pkg, ddrsdm_front, ddrsdm_queue and ddrsdm_back.
//
// One word in per clock, one result word out per input word, in order. After
// reset the block sweeps the single-port word memory to zero, one entry per
// cycle, over its 2**MEM_WORD_BITS entries (65536 at the default); full stays
// high until that pass ends. After that a word is taken every cycle while the
// four-entry queue has room; its result goes from the queue into the back
// end's result register, held there against pop. Beat addresses and burst
// state are settled in the front end, so the memory port does one read or one
// write per cycle and, while pop keeps up, sustains one word per cycle.
module ddr_sdram_device_model_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  clock_phase,
    input  logic        chip_select_n,
    input  logic        ras_n,
    input  logic        cas_n,
    input  logic        we_n,
    input  logic [2:0]  bank_select,
    input  logic [15:0] address,
    input  logic [15:0] write_data,
    input  logic [1:0]  write_strobe,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] read_data,
    output logic [1:0]  strobe_out,
    output logic        strobe_mismatch
);

    ddrsdm_pkg::beat_t front_word;
    ddrsdm_pkg::beat_t head_word;
    logic              accept;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              clear_busy;

    assign full   = q_full || clear_busy;
    assign accept = push && !full;

    ddrsdm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .clock_phase   (clock_phase),
        .chip_select_n (chip_select_n),
        .ras_n         (ras_n),
        .cas_n         (cas_n),
        .we_n          (we_n),
        .bank_select   (bank_select),
        .address       (address),
        .write_data    (write_data),
        .write_strobe  (write_strobe),
        .beat          (front_word)
    );

    ddrsdm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (front_word),
        .pop       (q_pop),
        .head_word (head_word),
        .full      (q_full),
        .empty     (q_empty)
    );

    ddrsdm_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_word          (head_word),
        .q_pop           (q_pop),
        .clear_busy      (clear_busy),
        .empty           (empty),
        .pop             (pop),
        .read_data       (read_data),
        .strobe_out      (strobe_out),
        .strobe_mismatch (strobe_mismatch)
    );

endmodule

[hw/rtl/ddrsdm_front.sv]
// Front end: command decode, bank/row/column tracking and beat scheduling.
// Depends on ddrsdm_pkg; emits one beat_t word per accepted input.
module ddrsdm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         clock_phase,
    input  logic               chip_select_n,
    input  logic               ras_n,
    input  logic               cas_n,
    input  logic               we_n,
    input  logic [2:0]         bank_select,
    input  logic [15:0]        address,
    input  logic [15:0]        write_data,
    input  logic [1:0]         write_strobe,
    output ddrsdm_pkg::beat_t  beat
);

    logic [1:0]                          phase_reg, phase_next;
    logic [4:0]                          lat_reg, lat_next;
    logic [3:0]                          beats_reg, beats_next;
    logic [15:0]                         row_reg, row_next;
    logic [ddrsdm_pkg::COL_BITS-1:0]     col_reg, col_next;
    logic [2:0]                          bank_reg, bank_next;
    logic [3:0]                          mode_reg, mode_next;
    logic [3:0]                          blen_reg, blen_next;
    logic [2:0]                          rl_reg, rl_next;
    logic [3:0]                          wl_reg, wl_next;
    logic [ddrsdm_pkg::ADDR_SUM_BITS-1:0] sum;

    assign sum = {row_reg, 13'd0}
               + {{(ddrsdm_pkg::ADDR_SUM_BITS-13){1'b0}}, bank_reg, 10'd0}
               + {{(ddrsdm_pkg::ADDR_SUM_BITS-ddrsdm_pkg::COL_BITS){1'b0}}, col_reg};

    always_comb
    begin
        phase_next = phase_reg;
        lat_next   = lat_reg;
        beats_next = beats_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        bank_next  = bank_reg;
        mode_next  = mode_reg;
        blen_next  = blen_reg;
        rl_next    = rl_reg;
        wl_next    = wl_reg;

        beat.op       = ddrsdm_pkg::OP_PASS;
        beat.addr     = sum[ddrsdm_pkg::MEM_WORD_BITS:1];
        beat.data     = write_data;
        beat.strobe   = write_strobe;
        beat.mismatch = 1'b0;

        if (!lat_reg[4])
        begin
            lat_next = lat_reg - 5'd1;
            if (phase_reg == ddrsdm_pkg::PH_READ)
            begin
                beat.strobe = ddrsdm_pkg::STROBE_HI;
            end
        end
        else if (phase_reg == ddrsdm_pkg::PH_READ && beats_reg != 4'd0)
        begin
            beats_next  = beats_reg - 4'd1;
            col_next    = col_reg + 17'd2;
            beat.op     = ddrsdm_pkg::OP_READ;
            beat.strobe = beats_next[0] ? ddrsdm_pkg::STROBE_LO : ddrsdm_pkg::STROBE_HI;
        end
        else if (phase_reg == ddrsdm_pkg::PH_WRITE && beats_reg != 4'd0)
        begin
            beats_next    = beats_reg - 4'd1;
            col_next      = col_reg + 17'd2;
            beat.op       = ddrsdm_pkg::OP_WRITE;
            beat.mismatch = (write_strobe != clock_phase);
        end

        if (clock_phase[0] && !chip_select_n)
        begin
            unique case ({ras_n, cas_n, we_n})
                ddrsdm_pkg::CMD_READ:
                begin
                    col_next   = {1'b0, address};
                    bank_next  = bank_select;
                    phase_next = ddrsdm_pkg::PH_READ;
                    lat_next   = {1'b0, rl_reg, 1'b0} - 5'd1;
                    beats_next = blen_reg;
                end
                ddrsdm_pkg::CMD_WRITE:
                begin
                    col_next   = {1'b0, address};
                    phase_next = ddrsdm_pkg::PH_WRITE;
                    lat_next   = {wl_reg, 1'b0} - 5'd2;
                    beats_next = blen_reg;
                end
                ddrsdm_pkg::CMD_ACT:
                begin
                    row_next = address;
                end
                ddrsdm_pkg::CMD_LMR:
                begin
                    if (bank_select == 3'd0)
                    begin
                        mode_next = {address[6:4], address[0]};
                    end
                    blen_next = mode_next[0] ? ddrsdm_pkg::BURST_LONG
                                             : ddrsdm_pkg::BURST_SHORT;
                    rl_next   = mode_next[3:1];
                    wl_next   = {1'b0, mode_next[3:1]} - 4'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ddrsdm_pkg::PH_IDLE;
            lat_reg   <= 5'd0;
            beats_reg <= 4'd0;
            row_reg   <= 16'd0;
            col_reg   <= '0;
            bank_reg  <= 3'd0;
            mode_reg  <= 4'd0;
            blen_reg  <= 4'd0;
            rl_reg    <= ddrsdm_pkg::RL_RESET;
            wl_reg    <= ddrsdm_pkg::WL_RESET;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            lat_reg   <= lat_next;
            beats_reg <= beats_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            bank_reg  <= bank_next;
            mode_reg  <= mode_next;
            blen_reg  <= blen_next;
            rl_reg    <= rl_next;
            wl_reg    <= wl_next;
        end
    end

endmodule

[hw/rtl/ddrsdm_queue.sv]
// Short word queue between the front end and the memory back end.
// Depends on ddrsdm_pkg for beat_t and depth constants.
module ddrsdm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ddrsdm_pkg::beat_t  push_word,
    input  logic               pop,
    output ddrsdm_pkg::beat_t  head_word,
    output logic               full,
    output logic               empty
);

    ddrsdm_pkg::beat_t                entry_reg [ddrsdm_pkg::Q_DEPTH];
    logic [ddrsdm_pkg::Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [ddrsdm_pkg::Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [ddrsdm_pkg::Q_PTR_BITS:0]   count_reg;

    assign full      = (count_reg == ddrsdm_pkg::Q_PTR_BITS'(0) + (ddrsdm_pkg::Q_PTR_BITS+1)'(ddrsdm_pkg::Q_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_word = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/ddrsdm_back.sv]
// Back end: word memory with clearing pass, beat execution and result register.
// Depends on ddrsdm_pkg; drains ddrsdm_queue and drives the result ports.
module ddrsdm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  ddrsdm_pkg::beat_t  q_word,
    output logic               q_pop,
    output logic               clear_busy,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        read_data,
    output logic [1:0]         strobe_out,
    output logic               strobe_mismatch
);

    logic [15:0]                          mem [ddrsdm_pkg::MEM_DEPTH];
    logic [15:0]                          rd_reg;
    logic                                 clr_busy_reg;
    logic [ddrsdm_pkg::MEM_WORD_BITS-1:0] clr_idx_reg;
    logic                                 valid_reg;
    logic                                 is_read_reg;
    logic [15:0]                          data_reg;
    logic [1:0]                           strobe_reg;
    logic                                 mis_reg;
    logic                                 adv;

    assign adv             = !clr_busy_reg && !q_empty && (!valid_reg || pop);
    assign q_pop           = adv;
    assign clear_busy      = clr_busy_reg;
    assign empty           = !valid_reg;
    assign read_data       = is_read_reg ? rd_reg : data_reg;
    assign strobe_out      = strobe_reg;
    assign strobe_mismatch = mis_reg;

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_idx_reg] <= 16'd0;
        end
        else if (adv && q_word.op == ddrsdm_pkg::OP_WRITE)
        begin
            mem[q_word.addr] <= q_word.data;
        end
        if (adv && q_word.op == ddrsdm_pkg::OP_READ)
        begin
            rd_reg <= mem[q_word.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            is_read_reg <= (q_word.op == ddrsdm_pkg::OP_READ);
            data_reg    <= q_word.data;
            strobe_reg  <= q_word.strobe;
            mis_reg     <= q_word.mismatch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

[verif/testbench.sv]
// Testbench for ddr_sdram_device_model_unit: drives DDR pin words through the push/full side
// and checks every popped word against an in-bench model of the device's burst/latency logic.
// Depends on ddrsdm_pkg and the RTL under hw/rtl.
`timescale 1ns / 100ps

module testbench;
    import ddrsdm_pkg::*;

    localparam logic [2:0] CMD_NOP = 3'b111;
    localparam logic [2:0] CMD_BST = 3'b110;
    localparam logic [2:0] CMD_PRE = 3'b010;
    localparam logic [2:0] CMD_REF = 3'b001;

    localparam int TOTAL_WORDS  = 1825;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 300000;

    typedef struct packed {
        logic [1:0]  phase;
        logic        cs_n;
        logic [2:0]  cmd;
        logic [2:0]  bank;
        logic [15:0] addr;
        logic [15:0] wdata;
        logic [1:0]  wstrobe;
    } pin_word_t;

    typedef struct packed {
        logic [15:0] data;
        logic [1:0]  strobe;
        logic        mismatch;
    } bus_word_t;

    class sdram_scoreboard;
        logic [15:0] mem_words [MEM_DEPTH];
        logic [1:0]  access;
        int          lat_cnt;
        logic [3:0]  beats;
        logic [15:0] open_row;
        logic [COL_BITS-1:0] col;
        logic [2:0]  bank;
        logic [15:0] mode0;
        logic [3:0]  blen;
        logic [2:0]  rd_lat;
        int          wr_lat;
        bus_word_t   expected_bus[$];
        int          errors;
        int          checked;
        int          read_beats;
        int          write_beats;
        int          mismatch_flags;

        function new();
            foreach (mem_words[i])
                mem_words[i] = '0;
            access   = PH_IDLE;
            lat_cnt  = 0;
            beats    = '0;
            open_row = '0;
            col      = '0;
            bank     = '0;
            mode0    = '0;
            blen     = '0;
            rd_lat   = RL_RESET;
            wr_lat   = int'(WL_RESET);
            errors   = 0;
            checked  = 0;
            read_beats = 0;
            write_beats = 0;
            mismatch_flags = 0;
        endfunction

        function logic [MEM_WORD_BITS-1:0] beat_addr();
            logic [31:0] p;
            p = (32'(open_row) << 13) + (32'(bank) << 10) + 32'(col);
            p = p & 32'h0FFF_FFFF;
            return p[MEM_WORD_BITS:1];
        endfunction

        function void note_word(pin_word_t w);
            bus_word_t r;
            r.data     = w.wdata;
            r.strobe   = w.wstrobe;
            r.mismatch = 1'b0;
            if (lat_cnt >= 0) begin
                lat_cnt--;
                if (access == PH_READ)
                    r.strobe = STROBE_HI;
            end else if (access == PH_READ && beats != 0) begin
                beats--;
                r.data = mem_words[beat_addr()];
                col += 2;
                r.strobe = beats[0] ? STROBE_LO : STROBE_HI;
                read_beats++;
            end else if (access == PH_WRITE && beats != 0) begin
                if (w.wstrobe != w.phase) begin
                    r.mismatch = 1'b1;
                    mismatch_flags++;
                end
                beats--;
                mem_words[beat_addr()] = w.wdata;
                col += 2;
                write_beats++;
            end
            if (w.phase[0] && !w.cs_n) begin
                case (w.cmd)
                    CMD_READ: begin
                        col     = COL_BITS'(w.addr);
                        bank    = w.bank;
                        access  = PH_READ;
                        lat_cnt = int'(rd_lat) * 2 - 1;
                        beats   = blen;
                    end
                    CMD_WRITE: begin
                        col     = COL_BITS'(w.addr);
                        access  = PH_WRITE;
                        lat_cnt = wr_lat * 2 - 2;
                        beats   = blen;
                    end
                    CMD_ACT: open_row = w.addr;
                    CMD_LMR: begin
                        if (w.bank == 3'd0)
                            mode0 = w.addr;
                        blen   = mode0[0] ? BURST_LONG : BURST_SHORT;
                        rd_lat = mode0[6:4];
                        wr_lat = int'(rd_lat) - 1;
                    end
                    default: ;
                endcase
            end
            expected_bus.push_back(r);
        endfunction

        function void check_word(bus_word_t got);
            bus_word_t exp_w;
            if (expected_bus.size() == 0) begin
                $error("unexpected result word: read_data %h strobe_out %h strobe_mismatch %b",
                       got.data, got.strobe, got.mismatch);
                errors++;
                return;
            end
            exp_w = expected_bus.pop_front();
            checked++;
            if (got.data !== exp_w.data) begin
                $error("read_data: expected %h, got %h", exp_w.data, got.data);
                errors++;
            end
            if (got.strobe !== exp_w.strobe) begin
                $error("strobe_out: expected %h, got %h", exp_w.strobe, got.strobe);
                errors++;
            end
            if (got.mismatch !== exp_w.mismatch) begin
                $error("strobe_mismatch: expected %b, got %b", exp_w.mismatch, got.mismatch);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  clock_phase = '0;
    logic        chip_select_n = 1'b1;
    logic        ras_n = 1'b1;
    logic        cas_n = 1'b1;
    logic        we_n = 1'b1;
    logic [2:0]  bank_select = '0;
    logic [15:0] address = '0;
    logic [15:0] write_data = '0;
    logic [1:0]  write_strobe = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] read_data;
    logic [1:0]  strobe_out;
    logic        strobe_mismatch;

    sdram_scoreboard sb = new();
    int          words_sent = 0;
    int          words_popped = 0;
    int          idle_cycles = 0;
    logic [1:0]  ddr_phase = '0;

    ddr_sdram_device_model_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .clock_phase     (clock_phase),
        .chip_select_n   (chip_select_n),
        .ras_n           (ras_n),
        .cas_n           (cas_n),
        .we_n            (we_n),
        .bank_select     (bank_select),
        .address         (address),
        .write_data      (write_data),
        .write_strobe    (write_strobe),
        .empty           (empty),
        .pop             (pop),
        .read_data       (read_data),
        .strobe_out      (strobe_out),
        .strobe_mismatch (strobe_mismatch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stretches of back-to-back traffic between randomly idling ones
    function automatic int draw_gap(int idx);
        return (idx % 256 < 64) ? 0 : $urandom_range(0, 19);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full)
                sb.note_word({clock_phase, chip_select_n, ras_n, cas_n, we_n, bank_select,
                              address, write_data, write_strobe});
            if (pop && !empty)
                sb.check_word({read_data, strobe_out, strobe_mismatch});
        end
    end

    task automatic send_word(input pin_word_t w);
        int gap;
        gap = draw_gap(words_sent);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push          <= 1'b1;
        clock_phase   <= w.phase;
        chip_select_n <= w.cs_n;
        {ras_n, cas_n, we_n} <= w.cmd;
        bank_select   <= w.bank;
        address       <= w.addr;
        write_data    <= w.wdata;
        write_strobe  <= w.wstrobe;
        do @(posedge clk); while (full);
        words_sent++;
    endtask

    task automatic send_raw(input logic [1:0] ph, input logic cs_n, input logic [2:0] cmd,
                            input logic [2:0] bs, input logic [15:0] addr,
                            input logic [15:0] wd, input logic [1:0] ws);
        send_word({ph, cs_n, cmd, bs, addr, wd, ws});
    endtask

    task automatic send_edge(input logic cs_n, input logic [2:0] cmd, input logic [2:0] bs,
                             input logic [15:0] addr, input bit bad_strobe);
        logic [1:0] ws;
        ws = bad_strobe ? (ddr_phase ^ 2'($urandom_range(1, 3))) : ddr_phase;
        send_raw(ddr_phase, cs_n, cmd, bs, addr, 16'($urandom), ws);
        ddr_phase++;
    endtask

    // data edge: pins are random where they cannot decode
    task automatic filler_edge();
        logic [2:0] cmd;
        logic       cs_n;
        cmd  = CMD_NOP;
        cs_n = 1'b0;
        if (!ddr_phase[0])
            cmd = 3'($urandom);
        else if ($urandom_range(0, 7) == 0) begin
            cs_n = 1'b1;
            cmd  = 3'($urandom);
        end
        send_edge(cs_n, cmd, 3'($urandom), 16'($urandom), $urandom_range(0, 15) == 0);
    endtask

    task automatic issue(input logic [2:0] cmd, input logic [2:0] bs, input logic [15:0] addr);
        if (!ddr_phase[0])
            filler_edge();
        send_edge(1'b0, cmd, bs, addr, 1'b0);
    endtask

    task automatic run_burst(input bit is_read);
        logic [15:0] col;
        logic [2:0]  bs;
        int          lat;
        int          n;
        col = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15) * 2);
        bs  = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1));
        issue(is_read ? CMD_READ : CMD_WRITE, bs, col);
        lat = is_read ? int'(sb.rd_lat) * 2 - 1 : sb.wr_lat * 2 - 2;
        n = (lat >= 0 ? lat + 1 : 0) + int'(sb.blen) + $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0)
            n = $urandom_range(0, n);
        repeat (n) filler_edge();
    endtask

    initial
    begin
        int gap;
        wait (rst_n);
        forever begin
            gap = draw_gap(words_popped);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            words_popped++;
        end
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pin extremes, commands before any mode load, zero latencies,
        // column carry past 16 bits, strobe mismatch, long burst load, even-edge command
        send_raw(2'd0, 1'b0, CMD_LMR,   3'd0, 16'h0000, 16'h0000, 2'd0);
        send_raw(2'd3, 1'b1, CMD_NOP,   3'd7, 16'hFFFF, 16'hFFFF, 2'd3);
        send_raw(2'd1, 1'b0, CMD_READ,  3'd5, 16'h0010, 16'h1234, 2'd1);
        send_raw(2'd3, 1'b0, CMD_WRITE, 3'd2, 16'h0020, 16'h4321, 2'd3);
        send_raw(2'd1, 1'b0, CMD_LMR,   3'd3, 16'hFFFF, 16'h0F0F, 2'd1);
        send_raw(2'd3, 1'b0, CMD_BST,   3'd0, 16'h0000, 16'h0000, 2'd3);
        send_raw(2'd1, 1'b0, CMD_PRE,   3'd1, 16'h0400, 16'h0000, 2'd1);
        send_raw(2'd3, 1'b0, CMD_REF,   3'd0, 16'h0000, 16'h0000, 2'd3);
        send_raw(2'd1, 1'b0, CMD_ACT,   3'd0, 16'hFFFF, 16'h0000, 2'd1);
        send_raw(2'd3, 1'b0, CMD_WRITE, 3'd0, 16'hFFFE, 16'h0000, 2'd3);
        send_raw(2'd0, 1'b0, CMD_NOP,   3'd0, 16'h0000, 16'hA5A5, 2'd0);
        send_raw(2'd1, 1'b0, CMD_NOP,   3'd0, 16'h0000, 16'h5A5A, 2'd2);
        send_raw(2'd2, 1'b0, CMD_NOP,   3'd0, 16'h0000, 16'hFFFF, 2'd2);
        send_raw(2'd3, 1'b0, CMD_NOP,   3'd0, 16'h0000, 16'h0001, 2'd3);
        send_raw(2'd1, 1'b0, CMD_READ,  3'd5, 16'hFFFE, 16'h0000, 2'd1);
        send_raw(2'd2, 1'b0, CMD_NOP,   3'd0, 16'h0000, 16'h0000, 2'd2);
        send_raw(2'd3, 1'b0, CMD_NOP,   3'd0, 16'h0000, 16'h0000, 2'd3);
        send_raw(2'd0, 1'b0, CMD_NOP,   3'd0, 16'h0000, 16'h0000, 2'd0);
        send_raw(2'd1, 1'b0, CMD_NOP,   3'd0, 16'h0000, 16'h0000, 2'd1);
        send_raw(2'd3, 1'b0, CMD_LMR,   3'd0, 16'h0071, 16'h0000, 2'd3);
        send_raw(2'd2, 1'b0, CMD_READ,  3'd0, 16'h0000, 16'h0000, 2'd2);
        ddr_phase = 2'd3;

        while (words_sent < TOTAL_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                issue(CMD_LMR, ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'd0,
                      16'($urandom));
            else if (pick < 20)
                issue(CMD_ACT, 3'($urandom),
                      ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)));
            else if (pick < 52)
                run_burst(1'b0);
            else if (pick < 85)
                run_burst(1'b1);
            else begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(pin_word_t'({$urandom, $urandom}));
                    ddr_phase = clock_phase + 2'd1;
                end
            end
        end
        push <= 1'b0;

        while (sb.expected_bus.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d pin words with %0d results checked: %0d read beats, %0d write beats, %0d strobe mismatch flags.",
                 words_sent, sb.checked, sb.read_beats, sb.write_beats, sb.mismatch_flags);
        if (sb.errors == 0 && sb.expected_bus.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/ddrsdm_pkg.sv
hw/rtl/ddrsdm_front.sv
hw/rtl/ddrsdm_queue.sv
hw/rtl/ddrsdm_back.sv
hw/rtl/ddr_sdram_device_model_unit.sv
verif/testbench.sv
